[rtl/sitda_pkg.sv]
// shared constants and types for the signed integer to decimal text core
// no dependencies

package sitda_pkg;

	localparam int VALUE_W = 32;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int CHAR_W  = 8;
	localparam int STEP_W  = $clog2(VALUE_W);
	localparam int DCNT_W  = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	typedef logic [3:0]       bcd_digit_t;
	typedef logic [BCD_W-1:0] bcd_word_t;

endpackage

[rtl/signed_int_to_decimal_ascii_core.sv]
// signed 32-bit integer to decimal ascii text, most significant character first
// depends on sitda_pkg
//
// sequence: a bit-serial shift-add-3 conversion of the magnitude, one input bit per cycle,
//   then a minus sign for a negative value, then the ten bcd digits, one digit per cycle out
//   of the bcd shift register, where leading zeros are silent; busy holds until the last
//   digit is sent, and a new request is taken only once the core is idle again
// reset: asynchronous, active low; clears the sequencer and the output strobe
// the receiver cannot stall: each character is on the ports for exactly one cycle

module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      strobe,
	output logic        [CHAR_W-1:0]  character,
	output logic                      last
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]         state_q;
	logic [VALUE_W-1:0] mag_q;      // magnitude, shifted out msb first
	bcd_word_t          bcd_q;      // ten packed bcd digits, top digit leaves first
	logic [STEP_W-1:0]  step_q;     // conversion step count
	logic [DCNT_W-1:0]  rem_q;      // digits still in the bcd register
	logic               neg_q;
	logic               started_q;  // first digit already sent

	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               accept;
	bcd_word_t          bcd_adj;
	bcd_digit_t         top_digit;
	logic               skip;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// add 3 to every digit of 5 or more before the next shift
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	// a leading zero is dropped unless it is the only digit left
	assign skip = !started_q && (top_digit == 4'd0) && (rem_q != DCNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			rem_q     <= '0;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q     <= value[VALUE_W-1];
						step_q    <= '0;
						started_q <= 1'b0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(VALUE_W - 1)) begin
						rem_q   <= DCNT_W'(DIGITS);
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					rem_q <= rem_q - DCNT_W'(1);
					if (!skip) begin
						strobe_q  <= 1'b1;
						started_q <= 1'b1;
						if (rem_q == DCNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// most negative value wraps to its own unsigned magnitude
					mag_q <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
				mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			end
			ST_SIGN: begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end
			ST_EMIT: begin
				bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
				char_q <= CHAR_ZERO + {4'd0, top_digit};
				last_q <= (rem_q == DCNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

`ifndef SYNTH
	// the end of a text is never directly followed by another character
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("character right after end of text");

	// an accepted request keeps the core busy in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("core not busy after request");

	// only a minus or a decimal digit is ever sent
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> (char_q == CHAR_MINUS) ||
			((char_q >= CHAR_ZERO) && (char_q <= CHAR_ZERO + 8'd9)))
		else $error("illegal character");

	// a minus sign is always followed by digits
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (char_q == CHAR_MINUS) |-> !last_q)
		else $error("minus sign marked last");
`endif

endmodule
